// ===== src/ngs_pkg.sv =====
// ----------------------------------------------------------------------------
// ngs_pkg
// Types and constants shared by the 2-D gravity integrator.
// ----------------------------------------------------------------------------
package ngs_pkg;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_STEP = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_NOP  = 2'd3;

  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_DT    = 2'd1;
  localparam logic [1:0] REG_GRAV  = 2'd2;

  localparam int unsigned APB_AW = 5;

  localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [48:0] MASS_ONE = 49'h1_0000_0000_0000;

  localparam logic [10:0] COUNT_RESET = 11'd1024;
  localparam logic [62:0] DT_RESET    = 63'd14073748835533;
  localparam logic [62:0] GRAV_RESET  = 63'd61547562;

  typedef struct packed {
    logic [1:0]         func;
    logic [9:0]         slot;
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic signed [63:0] vel_x;
    logic signed [63:0] vel_y;
    logic [48:0]        mass_in;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         out_slot;
    logic signed [63:0] out_pos_x;
    logic signed [63:0] out_pos_y;
    logic signed [63:0] out_vel_x;
    logic signed [63:0] out_vel_y;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [63:0] px;
    logic [63:0] py;
    logic [63:0] vx;
    logic [63:0] vy;
    logic [48:0] m;
  } body_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_OUT,
    ST_ROW_RD,
    ST_ROW_LD,
    ST_PAIR_RD,
    ST_PAIR_LD,
    ST_R2X,
    ST_R2Y,
    ST_SQRT,
    ST_S1,
    ST_S2,
    ST_TMUL,
    ST_TDIV,
    ST_TEND,
    ST_ACC,
    ST_FSAT,
    ST_ADV,
    ST_KMUL,
    ST_KDIV,
    ST_MEND,
    ST_WR
  } state_e;

endpackage

// ===== src/nbody_gravity_euler_step.sv =====
// ----------------------------------------------------------------------------
// nbody_gravity_euler_step
// All-pairs 2-D gravity with an explicit Euler step in Q16.48 fixed point.
// ----------------------------------------------------------------------------
// A load item is written straight into the body memory. A read item's result appears on
// result_o, marked by res_valid_o for one cycle, in the cycle after it is
// accepted. A step item keeps busy high through every pair of bodies,
// n*(n-1)/2 pairs, and through the move of each body; the time is set
// by the shared divider, which runs three times per axis for each pair, and
// the square-root unit. Bodies and force sums lie in memories with one read
// and one write port; no clearing pass is needed after reset.
module nbody_gravity_euler_step #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  ngs_pkg::in_item_t         item_i,
  output logic                      res_valid_o,
  output ngs_pkg::out_item_t        result_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ngs_pkg::APB_AW-1:0] paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);
  import ngs_pkg::*;

  localparam int AW   = $clog2(MAX_PARTICLES);
  localparam int CW   = AW + 1;
  localparam int AccW = 65 + AW;

  state_e state_q, state_d;
  logic   launched_q, launched_d;
  logic   flag_q, sat_set;

  logic [10:0] count_q;
  logic [62:0] dt_q, grav_q;

  // Memories
  body_t              body_mem [MAX_PARTICLES];
  logic [2*AccW-1:0]  sum_mem  [MAX_PARTICLES];
  body_t              bm_rdata_q, bm_wdata;
  logic [2*AccW-1:0]  sm_rdata_q, sm_wdata;
  logic [AW-1:0]      bm_raddr, bm_waddr, sm_raddr;
  logic               bm_we, sm_we;

  // Shared multiplier
  logic         mul_go, mul_busy_q;
  logic [1:0]   mul_cnt_q;
  logic [63:0]  mul_a, mul_b, mul_a_q, mul_b_q, mul_prod;
  logic [127:0] mul_p_q, mul_term;
  logic [1:0]   mul_sh;

  // Shared divider
  logic         div_go, div_busy_q, div_fail_q, div_ge;
  logic [5:0]   div_cnt_q;
  logic [127:0] div_n;
  logic [63:0]  div_d, div_d_q, div_rem_q, div_lo_q;
  logic [64:0]  div_rem2;

  // Square-root unit
  logic         sq_go, sq_busy_q, sq_ge;
  logic [5:0]   sq_cnt_q;
  logic [127:0] sq_x_q;
  logic [66:0]  sq_rem_q, sq_rem_s, sq_trial;
  logic [63:0]  sq_root_q;

  // Step datapath
  logic [CW-1:0]   q_q, k_q, n_q, n_c, q_inc, k_inc;
  body_t           bq_q, bk_q;
  logic [AccW-1:0] sqx_q, sqy_q, skx_q, sky_q;
  logic [AccW-1:0] sqx_n, sqy_n, skx_n, sky_n, txe, tye;
  logic [127:0]    r2_q, r2_sum, nq_q;
  logic [63:0]     r_q, s_q, tx_q, ty_q, fx_q, fy_q;
  logic [63:0]     npx_q, npy_q, nvx_q, nvy_q;
  logic            axis_q;
  logic [1:0]      dstg_q;
  logic [9:0]      slot_q;

  logic [64:0] diff_x, diff_y, mag_x, mag_y;
  logic        clamp_x, clamp_y, nx, ny, op_ready, slot_ok;
  logic [63:0] gx, gy, a_sel, v_sel, p_sel, f_sel, v_mag, f_mag, t_val;
  logic [64:0] adv_res, kick_res;
  logic        adv_big, fx_ovf, fy_ovf;
  logic [63:0] fx_val, fy_val;
  logic [48:0] mass_clamped;

  function automatic logic [63:0] sat_dir(input logic neg);
    return neg ? NEG_MIN : POS_MAX;
  endfunction

  function automatic logic [64:0] add_sat(input logic [63:0] base, input logic neg,
                                          input logic [63:0] mag);
    logic [65:0] sum;
    logic        ovf;
    sum = neg ? ({{2{base[63]}}, base} - {2'b00, mag})
              : ({{2{base[63]}}, base} + {2'b00, mag});
    ovf = (sum[65:63] != 3'b000) && (sum[65:63] != 3'b111);
    return {ovf, ovf ? sat_dir(sum[65]) : sum[63:0]};
  endfunction

  function automatic logic [64:0] acc_sat(input logic [AccW-1:0] acc);
    logic ovf;
    ovf = !((&acc[AccW-1:63]) || !(|acc[AccW-1:63]));
    return {ovf, ovf ? sat_dir(acc[AccW-1]) : acc[63:0]};
  endfunction

  // Configuration port
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[4:3])
      REG_COUNT: prdata = {53'd0, count_q};
      REG_DT:    prdata = {1'b0, dt_q};
      REG_GRAV:  prdata = {1'b0, grav_q};
      default:   prdata = 64'd0;
    endcase
  end

  // Combinational datapath
  assign diff_x  = {bq_q.px[63], bq_q.px} - {bk_q.px[63], bk_q.px};
  assign diff_y  = {bq_q.py[63], bq_q.py} - {bk_q.py[63], bk_q.py};
  assign mag_x   = diff_x[64] ? (65'd0 - diff_x) : diff_x;
  assign mag_y   = diff_y[64] ? (65'd0 - diff_y) : diff_y;
  assign clamp_x = mag_x > {1'b0, POS_MAX};
  assign clamp_y = mag_y > {1'b0, POS_MAX};
  assign gx      = clamp_x ? POS_MAX : mag_x[63:0];
  assign gy      = clamp_y ? POS_MAX : mag_y[63:0];
  assign nx      = ~diff_x[64];
  assign ny      = ~diff_y[64];
  assign a_sel   = axis_q ? gy : gx;
  assign r2_sum  = r2_q + mul_p_q;

  assign txe   = {{(AccW-64){1'b0}}, tx_q};
  assign tye   = {{(AccW-64){1'b0}}, ty_q};
  assign sqx_n = nx ? (sqx_q - txe) : (sqx_q + txe);
  assign skx_n = nx ? (skx_q + txe) : (skx_q - txe);
  assign sqy_n = ny ? (sqy_q - tye) : (sqy_q + tye);
  assign sky_n = ny ? (sky_q + tye) : (sky_q - tye);

  assign {fx_ovf, fx_val} = acc_sat(sqx_q);
  assign {fy_ovf, fy_val} = acc_sat(sqy_q);

  assign v_sel    = axis_q ? bq_q.vy : bq_q.vx;
  assign p_sel    = axis_q ? bq_q.py : bq_q.px;
  assign f_sel    = axis_q ? fy_q : fx_q;
  assign v_mag    = v_sel[63] ? (64'd0 - v_sel) : v_sel;
  assign f_mag    = f_sel[63] ? (64'd0 - f_sel) : f_sel;
  assign adv_big  = |mul_p_q[127:112];
  assign adv_res  = add_sat(p_sel, v_sel[63], mul_p_q[111:48]);
  assign kick_res = add_sat(v_sel, f_sel[63], div_lo_q);

  assign t_val = (div_fail_q || div_lo_q[63]) ? POS_MAX : div_lo_q;

  assign op_ready = launched_q && !mul_busy_q && !div_busy_q && !sq_busy_q;
  assign q_inc    = q_q + CW'(1);
  assign k_inc    = k_q + CW'(1);
  assign n_c      = (32'(count_q) < MAX_PARTICLES) ? CW'(count_q) : CW'(MAX_PARTICLES);
  assign slot_ok  = 32'(item_i.slot) < MAX_PARTICLES;
  assign mass_clamped = (item_i.mass_in > MASS_ONE) ? MASS_ONE : item_i.mass_in;

  // Next state and unit control
  always_comb begin
    state_d    = state_q;
    launched_d = launched_q;
    sat_set    = 1'b0;
    mul_go     = 1'b0;
    mul_a      = gx;
    mul_b      = gx;
    div_go     = 1'b0;
    div_n      = nq_q;
    div_d      = r_q;
    sq_go      = 1'b0;
    bm_raddr   = AW'(item_i.slot);
    sm_raddr   = q_q[AW-1:0];
    bm_we      = 1'b0;
    bm_waddr   = q_q[AW-1:0];
    bm_wdata   = '{px: npx_q, py: npy_q, vx: nvx_q, vy: nvy_q, m: bq_q.m};
    sm_we      = 1'b0;
    sm_wdata   = {skx_n, sky_n};
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          priority if (item_i.func == FUNC_LOAD && slot_ok) begin
            bm_we    = 1'b1;
            bm_waddr = AW'(item_i.slot);
            bm_wdata = '{px: item_i.pos_x, py: item_i.pos_y, vx: item_i.vel_x,
                         vy: item_i.vel_y, m: mass_clamped};
          end else if (item_i.func == FUNC_READ && slot_ok) begin
            state_d = ST_RD_OUT;
          end else if (item_i.func == FUNC_STEP && n_c != '0) begin
            state_d = ST_ROW_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_RD_OUT: state_d = ST_IDLE;
      ST_ROW_RD: begin
        bm_raddr = q_q[AW-1:0];
        state_d  = ST_ROW_LD;
      end
      ST_ROW_LD: state_d = (q_inc < n_q) ? ST_PAIR_RD : ST_FSAT;
      ST_PAIR_RD: begin
        bm_raddr = k_q[AW-1:0];
        sm_raddr = k_q[AW-1:0];
        state_d  = ST_PAIR_LD;
      end
      ST_PAIR_LD: state_d = ST_R2X;
      ST_R2X: begin
        if (!launched_q) begin
          mul_go     = 1'b1;
          launched_d = 1'b1;
          sat_set    = clamp_x | clamp_y;
        end else if (op_ready) begin
          launched_d = 1'b0;
          state_d    = ST_R2Y;
        end
      end
      ST_R2Y: begin
        mul_a = gy;
        mul_b = gy;
        if (!launched_q) begin
          mul_go     = 1'b1;
          launched_d = 1'b1;
        end else if (op_ready) begin
          launched_d = 1'b0;
          if (r2_sum == '0) begin
            sat_set = 1'b1;
            state_d = ST_ACC;
          end else begin
            state_d = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        if (!launched_q) begin
          sq_go      = 1'b1;
          launched_d = 1'b1;
        end else if (op_ready) begin
          launched_d = 1'b0;
          state_d    = ST_S1;
        end
      end
      ST_S1, ST_S2: begin
        mul_a = (state_q == ST_S1) ? {1'b0, grav_q} : s_q;
        mul_b = {15'd0, (state_q == ST_S1) ? bq_q.m : bk_q.m};
        if (!launched_q) begin
          mul_go     = 1'b1;
          launched_d = 1'b1;
        end else if (op_ready) begin
          launched_d = 1'b0;
          state_d    = (state_q == ST_S1) ? ST_S2 : ST_TMUL;
        end
      end
      ST_TMUL: begin
        mul_a = s_q;
        mul_b = a_sel;
        if (!launched_q) begin
          if (a_sel == '0 || s_q == '0) begin
            state_d = ST_TEND;
          end else begin
            mul_go     = 1'b1;
            launched_d = 1'b1;
          end
        end else if (op_ready) begin
          launched_d = 1'b0;
          state_d    = ST_TDIV;
        end
      end
      ST_TDIV: begin
        if (!launched_q) begin
          div_go     = 1'b1;
          launched_d = 1'b1;
        end else if (op_ready) begin
          launched_d = 1'b0;
          if (div_fail_q) begin
            sat_set = 1'b1;
            state_d = ST_TEND;
          end else if (dstg_q == 2'd2) begin
            sat_set = div_lo_q[63];
            state_d = ST_TEND;
          end
        end
      end
      ST_TEND: state_d = axis_q ? ST_ACC : ST_TMUL;
      ST_ACC: begin
        sm_we   = 1'b1;
        state_d = (k_inc < n_q) ? ST_PAIR_RD : ST_FSAT;
      end
      ST_FSAT: begin
        sat_set = fx_ovf | fy_ovf;
        state_d = ST_ADV;
      end
      ST_ADV: begin
        mul_a = {1'b0, dt_q};
        mul_b = v_mag;
        if (!launched_q) begin
          mul_go     = 1'b1;
          launched_d = 1'b1;
        end else if (op_ready) begin
          launched_d = 1'b0;
          sat_set    = adv_big | adv_res[64];
          state_d    = ST_KMUL;
        end
      end
      ST_KMUL: begin
        mul_a = {1'b0, dt_q};
        mul_b = f_mag;
        if (!launched_q) begin
          if (bq_q.m == '0) begin
            sat_set = 1'b1;
            state_d = ST_MEND;
          end else begin
            mul_go     = 1'b1;
            launched_d = 1'b1;
          end
        end else if (op_ready) begin
          launched_d = 1'b0;
          state_d    = ST_KDIV;
        end
      end
      ST_KDIV: begin
        div_d = {15'd0, bq_q.m};
        if (!launched_q) begin
          div_go     = 1'b1;
          launched_d = 1'b1;
        end else if (op_ready) begin
          launched_d = 1'b0;
          sat_set    = div_fail_q | kick_res[64];
          state_d    = ST_MEND;
        end
      end
      ST_MEND: state_d = axis_q ? ST_WR : ST_ADV;
      ST_WR: begin
        bm_we   = 1'b1;
        state_d = (q_inc < n_q) ? ST_ROW_RD : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      launched_q <= 1'b0;
      flag_q     <= 1'b0;
      count_q    <= COUNT_RESET;
      dt_q       <= DT_RESET;
      grav_q     <= GRAV_RESET;
      mul_busy_q <= 1'b0;
      mul_cnt_q  <= 2'd0;
      div_busy_q <= 1'b0;
      div_fail_q <= 1'b0;
      div_cnt_q  <= 6'd0;
      sq_busy_q  <= 1'b0;
      sq_cnt_q   <= 6'd0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      if (sat_set) begin
        flag_q <= 1'b1;
      end
      if (psel && penable && pwrite) begin
        unique case (paddr[4:3])
          REG_COUNT: count_q <= pwdata[10:0];
          REG_DT:    dt_q    <= pwdata[62:0];
          REG_GRAV:  grav_q  <= pwdata[62:0];
          default: ;
        endcase
      end
      if (mul_go) begin
        mul_busy_q <= 1'b1;
        mul_cnt_q  <= 2'd0;
      end else if (mul_busy_q) begin
        mul_cnt_q <= mul_cnt_q + 2'd1;
        if (mul_cnt_q == 2'd3) begin
          mul_busy_q <= 1'b0;
        end
      end
      if (div_go) begin
        div_cnt_q <= 6'd0;
        if (div_d == '0 || div_n[127:64] >= div_d) begin
          div_fail_q <= 1'b1;
          div_busy_q <= 1'b0;
        end else begin
          div_fail_q <= 1'b0;
          div_busy_q <= 1'b1;
        end
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q + 6'd1;
        if (div_cnt_q == 6'd63) begin
          div_busy_q <= 1'b0;
        end
      end
      if (sq_go) begin
        sq_busy_q <= 1'b1;
        sq_cnt_q  <= 6'd0;
      end else if (sq_busy_q) begin
        sq_cnt_q <= sq_cnt_q + 6'd1;
        if (sq_cnt_q == 6'd63) begin
          sq_busy_q <= 1'b0;
        end
      end
    end
  end

  // Arithmetic units
  assign mul_prod = {32'd0, mul_cnt_q[1] ? mul_a_q[63:32] : mul_a_q[31:0]} *
                    {32'd0, mul_cnt_q[0] ? mul_b_q[63:32] : mul_b_q[31:0]};
  assign mul_sh   = {1'b0, mul_cnt_q[0]} + {1'b0, mul_cnt_q[1]};
  assign mul_term = {64'd0, mul_prod} << {mul_sh, 5'd0};

  assign div_rem2 = {div_rem_q, div_lo_q[63]};
  assign div_ge   = div_rem2 >= {1'b0, div_d_q};

  assign sq_rem_s = {sq_rem_q[64:0], sq_x_q[127:126]};
  assign sq_trial = {1'b0, sq_root_q, 2'b01};
  assign sq_ge    = sq_rem_s >= sq_trial;

  always_ff @(posedge clk_i) begin
    if (mul_go) begin
      mul_a_q <= mul_a;
      mul_b_q <= mul_b;
      mul_p_q <= '0;
    end else if (mul_busy_q) begin
      mul_p_q <= mul_p_q + mul_term;
    end
    if (div_go) begin
      div_d_q   <= div_d;
      div_rem_q <= div_n[127:64];
      div_lo_q  <= div_n[63:0];
    end else if (div_busy_q) begin
      div_rem_q <= div_ge ? 64'(div_rem2 - {1'b0, div_d_q}) : div_rem2[63:0];
      div_lo_q  <= {div_lo_q[62:0], div_ge};
    end
    if (sq_go) begin
      sq_x_q    <= r2_q;
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (sq_busy_q) begin
      sq_x_q    <= {sq_x_q[125:0], 2'b00};
      sq_rem_q  <= sq_ge ? (sq_rem_s - sq_trial) : sq_rem_s;
      sq_root_q <= {sq_root_q[62:0], sq_ge};
    end
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      body_mem[bm_waddr] <= bm_wdata;
    end
    bm_rdata_q <= body_mem[bm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sm_we) begin
      sum_mem[k_q[AW-1:0]] <= sm_wdata;
    end
    sm_rdata_q <= sum_mem[sm_raddr];
  end

  // Step datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        slot_q <= item_i.slot;
        q_q    <= '0;
        n_q    <= n_c;
      end
      ST_ROW_LD: begin
        bq_q  <= bm_rdata_q;
        sqx_q <= (q_q == '0) ? '0 : sm_rdata_q[2*AccW-1:AccW];
        sqy_q <= (q_q == '0) ? '0 : sm_rdata_q[AccW-1:0];
        k_q   <= q_inc;
      end
      ST_PAIR_LD: begin
        bk_q  <= bm_rdata_q;
        skx_q <= (q_q == '0) ? '0 : sm_rdata_q[2*AccW-1:AccW];
        sky_q <= (q_q == '0) ? '0 : sm_rdata_q[AccW-1:0];
      end
      ST_R2X: begin
        if (op_ready) begin
          r2_q <= mul_p_q;
        end
      end
      ST_R2Y: begin
        if (op_ready) begin
          r2_q <= r2_sum;
          tx_q <= '0;
          ty_q <= '0;
        end
      end
      ST_SQRT: begin
        if (op_ready) begin
          r_q <= sq_root_q;
        end
      end
      ST_S1, ST_S2: begin
        if (op_ready) begin
          s_q <= mul_p_q[111:48];
        end
        axis_q <= 1'b0;
      end
      ST_TMUL: begin
        if (!launched_q && (a_sel == '0 || s_q == '0)) begin
          if (axis_q) begin
            ty_q <= '0;
          end else begin
            tx_q <= '0;
          end
        end
        if (op_ready) begin
          nq_q   <= mul_p_q;
          dstg_q <= 2'd0;
        end
      end
      ST_TDIV: begin
        if (op_ready) begin
          if (div_fail_q || dstg_q == 2'd2) begin
            if (axis_q) begin
              ty_q <= t_val;
            end else begin
              tx_q <= t_val;
            end
          end else if (dstg_q == 2'd0) begin
            nq_q   <= {16'd0, div_lo_q, 48'd0};
            dstg_q <= 2'd1;
          end else begin
            nq_q   <= {31'd0, div_lo_q, 33'd0};
            dstg_q <= 2'd2;
          end
        end
      end
      ST_TEND, ST_MEND: axis_q <= 1'b1;
      ST_ACC: begin
        sqx_q <= sqx_n;
        sqy_q <= sqy_n;
        k_q   <= k_inc;
      end
      ST_FSAT: begin
        fx_q   <= fx_val;
        fy_q   <= fy_val;
        axis_q <= 1'b0;
      end
      ST_ADV: begin
        if (op_ready) begin
          if (axis_q) begin
            npy_q <= adv_big ? sat_dir(v_sel[63]) : adv_res[63:0];
          end else begin
            npx_q <= adv_big ? sat_dir(v_sel[63]) : adv_res[63:0];
          end
        end
      end
      ST_KMUL: begin
        if (!launched_q && bq_q.m == '0) begin
          if (axis_q) begin
            nvy_q <= (f_sel != '0) ? sat_dir(f_sel[63]) : v_sel;
          end else begin
            nvx_q <= (f_sel != '0) ? sat_dir(f_sel[63]) : v_sel;
          end
        end
        if (op_ready) begin
          nq_q <= mul_p_q;
        end
      end
      ST_KDIV: begin
        if (op_ready) begin
          if (axis_q) begin
            nvy_q <= div_fail_q ? sat_dir(f_sel[63]) : kick_res[63:0];
          end else begin
            nvx_q <= div_fail_q ? sat_dir(f_sel[63]) : kick_res[63:0];
          end
        end
      end
      ST_WR: q_q <= q_inc;
      default: ;
    endcase
  end

  // Outputs
  assign busy        = state_q != ST_IDLE;
  assign res_valid_o = state_q == ST_RD_OUT;
  assign result_o    = '{out_slot: slot_q, out_pos_x: bm_rdata_q.px,
                         out_pos_y: bm_rdata_q.py, out_vel_x: bm_rdata_q.vx,
                         out_vel_y: bm_rdata_q.vy, saturated: flag_q};

`ifndef SYNTH
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_busy_q, div_busy_q, sq_busy_q}))
    else $error("Arithmetic units active together.");

  a_unit_launched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_busy_q || div_busy_q || sq_busy_q) |-> launched_q)
    else $error("Arithmetic unit running without a pending operation.");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> (k_q > q_q && k_q < n_q))
    else $error("Pair indices out of order.");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("Result strobe held for more than one cycle.");

  a_flag_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(flag_q))
    else $error("Saturation flag cleared outside reset.");
`endif

endmodule

// ===== tb/sv/nbody_gravity_euler_step_tb.sv =====
// ----------------------------------------------------------------------------
// nbody_gravity_euler_step_tb
// Self-checking bench for the fixed-point 2-D gravity integrator.
// Bodies are loaded, stepped and read back through the command port while
// the register port sets the body count, the time step and G. A bit-exact
// model inside the bench predicts every body read, and each returned item
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module nbody_gravity_euler_step_tb;
  import ngs_pkg::*;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  cfg_reg;
    logic [63:0] cfg_val;
    in_item_t    item;
    bit          typed;
    out_item_t   res;
  } row_t;

  localparam int NBODY = 1024;
  localparam int RAND_ITEMS = 580;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_item_t    item_i;
  logic        res_valid_o;
  out_item_t   result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [APB_AW-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  nbody_gravity_euler_step i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .res_valid_o(res_valid_o),
    .result_o   (result_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Predicted body state and registers.
  logic [63:0] pos_x_m [NBODY];
  logic [63:0] pos_y_m [NBODY];
  logic [63:0] vel_x_m [NBODY];
  logic [63:0] vel_y_m [NBODY];
  logic [48:0] mass_m  [NBODY];
  bit          loaded_m[NBODY];
  logic signed [127:0] force_x_sum[NBODY];
  logic signed [127:0] force_y_sum[NBODY];
  logic [63:0] frc_x[NBODY];
  logic [63:0] frc_y[NBODY];
  bit          sat_m;
  logic [10:0] count_m;
  logic [63:0] dt_m;
  logic [63:0] grav_m;

  out_item_t   pending_reads[$];
  int          loaded_slots[$];
  row_t        plan[$];
  int          errors;
  int          reads_seen;
  int          steps_done;
  int          items_sent;
  bit          calm;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("FAILURE");
    $finish;
  end

  // ---------------- fixed-point arithmetic -----------------------------------
  function automatic logic [63:0] sat_dir(logic neg);
    return neg ? NEG_MIN : POS_MAX;
  endfunction

  function automatic logic [63:0] magnitude(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] clamp64(logic signed [127:0] a);
    if (a[127:63] == '0 || a[127:63] == '1) return a[63:0];
    sat_m = 1'b1;
    return sat_dir(a[127]);
  endfunction

  function automatic logic signed [127:0] add_mag(logic signed [127:0] acc, logic neg,
                                                  logic [63:0] mag);
    logic signed [127:0] ext;
    ext = {64'd0, mag};
    return neg ? acc - ext : acc + ext;
  endfunction

  function automatic logic [63:0] separation(logic [63:0] a, logic [63:0] b);
    logic [63:0] m;
    m = ($signed(a) < $signed(b)) ? b - a : a - b;
    if (m > POS_MAX) begin
      m = POS_MAX;
      sat_m = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [63:0] root128(logic [127:0] n);
    logic [63:0] res;
    logic [63:0] c;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) res = c;
    end
    return res;
  endfunction

  function automatic logic [63:0] scale48(logic [63:0] a, logic [63:0] b);
    logic [127:0] t;
    t = {64'd0, a} * {64'd0, b};
    return t[111:48];
  endfunction

  function automatic bit quot64(logic [127:0] n, logic [63:0] d, output logic [63:0] q);
    logic [127:0] t;
    q = '0;
    if (d == 0) return 0;
    t = n / {64'd0, d};
    if (t[127:64] != 0) return 0;
    q = t[63:0];
    return 1;
  endfunction

  function automatic logic [63:0] axis_pull(logic [63:0] s, logic [63:0] a, logic [63:0] r);
    logic [63:0] u;
    logic [63:0] v;
    logic [63:0] t;
    if (a == 0 || s == 0) return '0;
    if (!quot64({64'd0, s} * {64'd0, a}, r, u) ||
        !quot64({64'd0, u} << 48, r, v) ||
        !quot64({64'd0, v} << 33, r, t) || t > POS_MAX) begin
      sat_m = 1'b1;
      return POS_MAX;
    end
    return t;
  endfunction

  function automatic logic [63:0] drift(logic [63:0] base, logic [63:0] rate);
    logic [127:0] p;
    p = {64'd0, dt_m} * {64'd0, magnitude(rate)};
    if (p[127:112] != 0) begin
      sat_m = 1'b1;
      return sat_dir(rate[63]);
    end
    return clamp64(add_mag({{64{base[63]}}, base}, rate[63], p[111:48]));
  endfunction

  function automatic logic [63:0] kick(logic [63:0] vel, logic [63:0] f, logic [48:0] m);
    logic [63:0] fm;
    logic [63:0] dv;
    fm = magnitude(f);
    if (m == 0) begin
      sat_m = 1'b1;
      return (fm != 0) ? sat_dir(f[63]) : vel;
    end
    if (!quot64({64'd0, dt_m} * {64'd0, fm}, {15'd0, m}, dv)) begin
      sat_m = 1'b1;
      return sat_dir(f[63]);
    end
    return clamp64(add_mag({{64{vel[63]}}, vel}, f[63], dv));
  endfunction

  function automatic void integrate_step();
    int n;
    logic [63:0]  ax;
    logic [63:0]  ay;
    logic [127:0] r2;
    logic [63:0]  r;
    logic [63:0]  s;
    logic [63:0]  tx;
    logic [63:0]  ty;
    logic         nx;
    logic         ny;
    n = (count_m > NBODY) ? NBODY : int'(count_m);
    for (int q = 0; q < n; q++) begin
      force_x_sum[q] = '0;
      force_y_sum[q] = '0;
    end
    for (int q = 0; q < n; q++) begin
      for (int k = q + 1; k < n; k++) begin
        ax = separation(pos_x_m[q], pos_x_m[k]);
        ay = separation(pos_y_m[q], pos_y_m[k]);
        r2 = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
        if (r2 == 0) begin
          sat_m = 1'b1;
          continue;
        end
        r  = root128(r2);
        s  = scale48(scale48(grav_m, {15'd0, mass_m[q]}), {15'd0, mass_m[k]});
        tx = axis_pull(s, ax, r);
        ty = axis_pull(s, ay, r);
        nx = !($signed(pos_x_m[q]) < $signed(pos_x_m[k]));
        ny = !($signed(pos_y_m[q]) < $signed(pos_y_m[k]));
        force_x_sum[q] = add_mag(force_x_sum[q], nx, tx);
        force_x_sum[k] = add_mag(force_x_sum[k], !nx, tx);
        force_y_sum[q] = add_mag(force_y_sum[q], ny, ty);
        force_y_sum[k] = add_mag(force_y_sum[k], !ny, ty);
      end
    end
    for (int q = 0; q < n; q++) begin
      frc_x[q] = clamp64(force_x_sum[q]);
      frc_y[q] = clamp64(force_y_sum[q]);
    end
    for (int q = 0; q < n; q++) begin
      pos_x_m[q] = drift(pos_x_m[q], vel_x_m[q]);
      pos_y_m[q] = drift(pos_y_m[q], vel_y_m[q]);
      vel_x_m[q] = kick(vel_x_m[q], frc_x[q], mass_m[q]);
      vel_y_m[q] = kick(vel_y_m[q], frc_y[q], mass_m[q]);
    end
  endfunction

  // Returns 1 and the predicted body when the item is a read.
  function automatic bit apply_item(in_item_t it, output out_item_t res);
    res = '0;
    case (it.func)
      FUNC_STEP: begin
        integrate_step();
        steps_done++;
      end
      FUNC_LOAD: begin
        pos_x_m[it.slot] = it.pos_x;
        pos_y_m[it.slot] = it.pos_y;
        vel_x_m[it.slot] = it.vel_x;
        vel_y_m[it.slot] = it.vel_y;
        mass_m[it.slot]  = (it.mass_in > MASS_ONE) ? MASS_ONE : it.mass_in;
        if (!loaded_m[it.slot]) loaded_slots.push_back(it.slot);
        loaded_m[it.slot] = 1'b1;
      end
      FUNC_READ: begin
        res = '{it.slot, pos_x_m[it.slot], pos_y_m[it.slot], vel_x_m[it.slot],
                vel_y_m[it.slot], sat_m};
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  // ---------------- stimulus helpers -----------------------------------------
  function automatic in_item_t mk_item(logic [1:0] func, logic [9:0] slot, logic [63:0] px,
                                       logic [63:0] py, logic [63:0] vx, logic [63:0] vy,
                                       logic [48:0] m);
    return '{func, slot, px, py, vx, vy, m};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_coord(int shift);
    logic signed [63:0] v;
    v = rand64();
    if ($urandom_range(0, 3) == 0) return v;
    return v >>> shift;
  endfunction

  function automatic in_item_t rand_load(logic [9:0] slot);
    logic [48:0] m;
    m = ($urandom_range(0, 9) == 0) ? rand64() : {1'b0, rand64() >> 16};
    return mk_item(FUNC_LOAD, slot, rand_coord(12), rand_coord(12), rand_coord(18),
                   rand_coord(18), m);
  endfunction

  task automatic issue(in_item_t it);
    out_item_t res;
    item_i <= it;
    start  <= 1'b1;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (apply_item(it, res)) pending_reads.push_back(res);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (busy || pending_reads.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    logic [63:0] want;
    case (idx)
      REG_COUNT: begin
        count_m = val[10:0];
        want = {53'd0, val[10:0]};
      end
      REG_DT: begin
        dt_m = val & POS_MAX;
        want = dt_m;
      end
      default: begin
        grav_m = val & POS_MAX;
        want = grav_m;
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 3'b000});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $display("%0t register %0d: expected %h, got %h", $time, idx, want, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_item(in_item_t it);
    plan.push_back('{ROW_ITEM, REG_COUNT, 64'd0, it, 1'b0, '0});
  endtask

  task automatic add_read(logic [9:0] slot, bit typed, out_item_t res);
    plan.push_back('{ROW_ITEM, REG_COUNT, 64'd0, mk_item(FUNC_READ, slot, 0, 0, 0, 0, 0),
                     typed, res});
  endtask

  task automatic add_cfg(logic [1:0] idx, logic [63:0] val);
    plan.push_back('{ROW_CFG, idx, val, '0, 1'b0, '0});
  endtask

  // ---------------- result checking ------------------------------------------
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_reads.size() == 0) begin
        $display("%0t unexpected body item: expected none, got %p", $time, result_o);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        reads_seen++;
        check_field("out_slot", 64'(want.out_slot), 64'(result_o.out_slot));
        check_field("out_pos_x", want.out_pos_x, result_o.out_pos_x);
        check_field("out_pos_y", want.out_pos_y, result_o.out_pos_y);
        check_field("out_vel_x", want.out_vel_x, result_o.out_vel_x);
        check_field("out_vel_y", want.out_vel_y, result_o.out_vel_y);
        check_field("saturated", 64'(want.saturated), 64'(result_o.saturated));
      end
    end
  end

  // ---------------- main sequence --------------------------------------------
  initial begin
    out_item_t res;
    in_item_t  it;
    int        n;
    int        pick;
    rst_ni  = 1'b0;
    start   = 1'b0;
    item_i  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    errors = 0;
    reads_seen = 0;
    steps_done = 0;
    items_sent = 0;
    calm = 1'b0;
    sat_m = 1'b0;
    count_m = COUNT_RESET;
    dt_m = {1'b0, DT_RESET};
    grav_m = {1'b0, GRAV_RESET};
    for (int i = 0; i < NBODY; i++) loaded_m[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Extremes of every field, read back before any step.
    add_cfg(REG_COUNT, 64'd2047);
    add_item(mk_item(FUNC_LOAD, 10'd0, POS_MAX, NEG_MIN, POS_MAX, NEG_MIN, 49'd0));
    add_read(10'd0, 1, '{10'd0, POS_MAX, NEG_MIN, POS_MAX, NEG_MIN, 1'b0});
    add_item(mk_item(FUNC_LOAD, 10'd1023, NEG_MIN, POS_MAX, NEG_MIN, POS_MAX, '1));
    add_read(10'd1023, 1, '{10'd1023, NEG_MIN, POS_MAX, NEG_MIN, POS_MAX, 1'b0});
    add_item(mk_item(FUNC_NOP, 10'd5, '1, '1, '1, '1, '1));
    add_item(mk_item(FUNC_LOAD, 10'd1, NEG_MIN, POS_MAX, 64'd0, '1, MASS_ONE));
    // Huge separation, a massless body and runaway sums.
    add_cfg(REG_COUNT, 64'd2);
    add_item(mk_item(FUNC_STEP, 10'd0, 0, 0, 0, 0, 0));
    add_read(10'd0, 0, '0);
    add_read(10'd1, 0, '0);
    // Bodies almost touching with the largest G and dt overflow the quotients.
    add_cfg(REG_DT, POS_MAX);
    add_cfg(REG_GRAV, '1);
    add_item(mk_item(FUNC_LOAD, 10'd0, 64'd0, 64'd0, 64'd1, 64'd0, MASS_ONE));
    add_item(mk_item(FUNC_LOAD, 10'd1, 64'd1, 64'd0, 64'd0, 64'd0, MASS_ONE));
    add_item(mk_item(FUNC_STEP, 10'd0, 0, 0, 0, 0, 0));
    add_read(10'd1, 0, '0);
    // Body 1 placed at rest on the origin.
    add_item(mk_item(FUNC_LOAD, 10'd1, 64'd0, 64'd0, 64'd0, 64'd0, MASS_ONE));
    add_item(mk_item(FUNC_STEP, 10'd0, 0, 0, 0, 0, 0));
    add_read(10'd0, 0, '0);
    // No bodies, then one body that only drifts.
    add_cfg(REG_COUNT, 64'd0);
    add_item(mk_item(FUNC_STEP, 10'd0, 0, 0, 0, 0, 0));
    add_read(10'd0, 0, '0);
    add_cfg(REG_COUNT, 64'd1);
    add_item(mk_item(FUNC_STEP, 10'd0, 0, 0, 0, 0, 0));
    add_read(10'd0, 0, '0);
    add_cfg(REG_DT, 64'd0);
    add_cfg(REG_GRAV, 64'd0);
    add_cfg(REG_COUNT, 64'd2);
    add_item(mk_item(FUNC_STEP, 10'd0, 0, 0, 0, 0, 0));
    add_read(10'd1, 0, '0);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        reg_write(plan[i].cfg_reg, plan[i].cfg_val);
      end else begin
        issue(plan[i].item);
        if (plan[i].typed) void'(pending_reads.pop_back());
        if (plan[i].typed) pending_reads.push_back(plan[i].res);
        maybe_pause();
      end
    end

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 9; ph++) begin
      calm = (ph == 8);
      settle();
      pick = $urandom_range(0, 9);
      n = (pick == 0) ? 0 : (pick == 1) ? 1 : $urandom_range(2, 6);
      reg_write(REG_COUNT, 64'(n));
      case ($urandom_range(0, 3))
        0: reg_write(REG_DT, {1'b0, DT_RESET});
        1: reg_write(REG_DT, rand64() >> $urandom_range(1, 63));
        2: reg_write(REG_DT, rand64());
        default: reg_write(REG_DT, (ph == 3) ? 64'd0 : POS_MAX);
      endcase
      case ($urandom_range(0, 2))
        0: reg_write(REG_GRAV, {1'b0, GRAV_RESET});
        1: reg_write(REG_GRAV, rand64() >> $urandom_range(1, 63));
        default: reg_write(REG_GRAV, rand64());
      endcase
      for (int s = 0; s < ((n > 1) ? n : 1); s++) begin
        issue(rand_load(10'(s)));
        maybe_pause();
      end
      for (int k = 0; k < RAND_ITEMS / 9; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          it = rand_load(($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                                     : 10'($urandom_range(0, 7)));
        end else if (pick < 72) begin
          it = mk_item(FUNC_READ, 10'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]),
                       rand64(), rand64(), rand64(), rand64(), rand64());
        end else if (pick < 86) begin
          it = mk_item(FUNC_STEP, 10'($urandom), rand64(), rand64(), rand64(), rand64(),
                       rand64());
        end else begin
          it = mk_item(FUNC_NOP, 10'($urandom), rand64(), rand64(), rand64(), rand64(),
                       rand64());
        end
        issue(it);
        maybe_pause();
      end
    end

    start <= 1'b0;
    do @(posedge clk_i); while (busy || pending_reads.size() != 0);
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d items, %0d time steps and %0d body reads checked.",
             items_sent, steps_done, reads_seen);
    $display("Mismatches found: %0d", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
